FILE: src/usfp_pkg.sv
// usfp_pkg: shared constants and codes for the uart state and frame parser
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package usfp_pkg;

  localparam int unsigned FRAME_CAPACITY_DEF = 31;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;

  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TELEMETRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONTEXT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_STATE = 2'd2;

  localparam logic [BYTE_W-1:0] OPEN_TELEMETRY  = 8'hFE;
  localparam logic [BYTE_W-1:0] OPEN_CONTEXT    = 8'hFC;
  localparam logic [BYTE_W-1:0] END_OF_FRAME    = 8'h0A;
  localparam logic [BYTE_W-1:0] FIRST_PRINTABLE = 8'h20;

  localparam logic [TICK_W-1:0]  TIMEOUT_RESET   = 16'd3000;
  localparam logic [TICK_W-1:0]  SILENCE_MAX     = 16'hFFFF;
  localparam logic [STATE_W-1:0] SLEEP_RESET     = 3'd0;
  localparam logic [STATE_W-1:0] TOP_STATE_RESET = 3'd7;

endpackage

`default_nettype wire

FILE: src/usfp_if.sv
// usfp_in_if and usfp_out_if: valid/ready channels for input events and results
// depends on usfp_pkg for field widths
`default_nettype none

interface usfp_in_if;
  import usfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface usfp_out_if;
  import usfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] link_state;
  logic               timed_out;
  logic [KIND_W-1:0]  frame_kind;
  logic [BYTE_W-1:0]  frame_char;
  logic [INDEX_W-1:0] char_index;
  logic               frame_empty;
  logic               last;

  modport source (output valid, link_state, timed_out, frame_kind, frame_char,
                  char_index, frame_empty, last, input ready);
  modport sink   (input valid, link_state, timed_out, frame_kind, frame_char,
                  char_index, frame_empty, last, output ready);
endinterface

`default_nettype wire

FILE: src/usfp_frame_buf.sv
// usfp_frame_buf: frame character store, one write port, one registered read port
// depends on usfp_pkg for the byte width
`default_nettype none

module usfp_frame_buf #(
  parameter int unsigned DEPTH = usfp_pkg::FRAME_CAPACITY_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [usfp_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [usfp_pkg::BYTE_W-1:0] rd_data
);
  import usfp_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/uart_state_and_frame_parser.sv
// uart_state_and_frame_parser: link state and frame parser over received bytes
// a byte or tick event is taken when idle; its result is registered in S_EMIT once the
// output slot is free; a commit passes through S_READ and S_EMIT for each character, as
// the frame store has a single registered read port; not ready until the last result is
// registered; reset is synchronous (rst_n low): control and config registers to defaults,
// output fields not reset, no frame open, store not cleared
`default_nettype none

module uart_state_and_frame_parser #(
  parameter int unsigned FRAME_CAPACITY = usfp_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  usfp_in_if.sink                         in_if,
  usfp_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [usfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [usfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import usfp_pkg::*;

  localparam int unsigned ADDR_W = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
  localparam int unsigned LEN_W  = $clog2(FRAME_CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [TICK_W-1:0]  timeout_r;
  logic [STATE_W-1:0] sleep_r;
  logic [STATE_W-1:0] top_r;
  logic [STATE_W-1:0] code_r, code_nxt;
  logic [TICK_W-1:0]  silence_r, silence_nxt;
  logic [KIND_W-1:0]  collect_r, collect_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic               walk_r, walk_nxt;
  logic [KIND_W-1:0]  emit_kind_r, emit_kind_nxt;
  logic               emit_empty_r, emit_empty_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0] out_state_r, out_state_nxt;
  logic               out_to_r, out_to_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0]  out_char_r, out_char_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_ready;
  logic               in_take;
  logic               wr_en;
  logic [BYTE_W-1:0]  rd_data;
  logic               timed_out;
  logic               walk_last;
  logic               slot_free;

  usfp_frame_buf #(.DEPTH(FRAME_CAPACITY)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len_r[ADDR_W-1:0]),
    .wr_data (in_if.rx_byte),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_take   = in_if.valid && in_ready;
  assign timed_out = (silence_r > timeout_r);
  assign walk_last = ((idx_r + LEN_W'(1)) == len_r);
  assign slot_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    silence_nxt    = silence_r;
    collect_nxt    = collect_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    walk_nxt       = walk_r;
    emit_kind_nxt  = emit_kind_r;
    emit_empty_nxt = emit_empty_r;
    wr_en          = 1'b0;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_state_nxt  = out_state_r;
    out_to_nxt     = out_to_r;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_index_nxt  = out_index_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt      = S_EMIT;
          walk_nxt       = 1'b0;
          emit_kind_nxt  = KIND_NONE;
          emit_empty_nxt = 1'b0;
          if (in_if.mode == MODE_TICK) begin
            if (silence_r != SILENCE_MAX) begin
              silence_nxt = silence_r + TICK_W'(1);
            end
          end else if (in_if.mode == MODE_BYTE) begin
            silence_nxt = '0;
            if (collect_r != KIND_NONE) begin
              if (in_if.rx_byte == END_OF_FRAME) begin
                collect_nxt   = KIND_NONE;
                emit_kind_nxt = collect_r;
                if (len_r == '0) begin
                  emit_empty_nxt = 1'b1;
                end else begin
                  walk_nxt  = 1'b1;
                  idx_nxt   = '0;
                  state_nxt = S_READ;
                end
              end else if (in_if.rx_byte >= FIRST_PRINTABLE &&
                           len_r < LEN_W'(FRAME_CAPACITY)) begin
                wr_en   = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end
            end else if (in_if.rx_byte == OPEN_TELEMETRY) begin
              collect_nxt = KIND_TELEMETRY;
              len_nxt     = '0;
            end else if (in_if.rx_byte == OPEN_CONTEXT) begin
              collect_nxt = KIND_CONTEXT;
              len_nxt     = '0;
            end else if (in_if.rx_byte <= {5'd0, top_r}) begin
              code_nxt = in_if.rx_byte[STATE_W-1:0];
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_state_nxt = timed_out ? sleep_r : code_r;
          out_to_nxt    = timed_out;
          out_kind_nxt  = emit_kind_r;
          out_empty_nxt = emit_empty_r;
          if (walk_r) begin
            out_char_nxt  = rd_data;
            out_index_nxt = INDEX_W'(idx_r);
            out_last_nxt  = walk_last;
          end else begin
            out_char_nxt  = '0;
            out_index_nxt = '0;
            out_last_nxt  = 1'b1;
          end
          if (walk_r && !walk_last) begin
            idx_nxt   = idx_r + LEN_W'(1);
            state_nxt = S_READ;
          end else begin
            walk_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RESET;
      sleep_r      <= SLEEP_RESET;
      top_r        <= TOP_STATE_RESET;
      code_r       <= SLEEP_RESET;
      silence_r    <= '0;
      collect_r    <= KIND_NONE;
      len_r        <= '0;
      idx_r        <= '0;
      walk_r       <= 1'b0;
      emit_kind_r  <= KIND_NONE;
      emit_empty_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      code_r       <= code_nxt;
      silence_r    <= silence_nxt;
      collect_r    <= collect_nxt;
      len_r        <= len_nxt;
      idx_r        <= idx_nxt;
      walk_r       <= walk_nxt;
      emit_kind_r  <= emit_kind_nxt;
      emit_empty_r <= emit_empty_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT:   timeout_r <= cfg_wdata[TICK_W-1:0];
          REG_SLEEP:     sleep_r   <= cfg_wdata[STATE_W-1:0];
          REG_TOP_STATE: top_r     <= cfg_wdata[STATE_W-1:0];
          default: begin
          end
        endcase
      end
    end
    out_state_r <= out_state_nxt;
    out_to_r    <= out_to_nxt;
    out_kind_r  <= out_kind_nxt;
    out_char_r  <= out_char_nxt;
    out_index_r <= out_index_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.link_state  = out_state_r;
  assign out_if.timed_out   = out_to_r;
  assign out_if.frame_kind  = out_kind_r;
  assign out_if.frame_char  = out_char_r;
  assign out_if.char_index  = out_index_r;
  assign out_if.frame_empty = out_empty_r;
  assign out_if.last        = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(FRAME_CAPACITY))
    else $error("frame length beyond capacity");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ready)
    else $error("ready right after an accepted word");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && out_char_r == '0)
    else $error("empty frame result not final");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> idx_r < len_r)
    else $error("read index past frame length");

endmodule

`default_nettype wire
